/* hdl/emr_pkg.sv */
package emr_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int MASS_W      = 31;
  localparam int ACC_W       = 64;
  localparam int HALF_W      = ACC_W / 2;
  localparam int PROD_W      = 2 * ACC_W;
  localparam int QUEUE_DEPTH = 2;

  // Corrected velocity: the input velocity plus the reduced force product, kept exactly.
  localparam int VEL_W = (((2 * DATA_W - FRAC_BITS) > DATA_W) ?
                          (2 * DATA_W - FRAC_BITS) : DATA_W) + 1;

  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};

  typedef struct packed {
    logic        [MASS_W-1:0] mass;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] vel_z;
    logic signed [DATA_W-1:0] force_x;
    logic signed [DATA_W-1:0] force_y;
    logic signed [DATA_W-1:0] force_z;
    logic signed [DATA_W-1:0] potential;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] total_energy;
    logic signed [ACC_W-1:0] potential_energy;
    logic signed [ACC_W-1:0] kinetic_energy;
    logic signed [ACC_W-1:0] momentum_x;
    logic signed [ACC_W-1:0] momentum_y;
    logic signed [ACC_W-1:0] momentum_z;
    logic signed [ACC_W-1:0] angular_x;
    logic signed [ACC_W-1:0] angular_y;
    logic signed [ACC_W-1:0] angular_z;
  } out_item_t;

  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef struct packed {
    op_e      op;
    in_item_t item;
  } q_entry_t;

  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] res;
  } mul_rsp_t;

endpackage

/* hdl/energy_momentum_reduction_top.sv */
// Energy and momentum reduction over a stream of particles in Q16.16 fixed point. Each
// input transaction carries one particle; its velocity is corrected by force times the
// configured half step, and eight saturating 64-bit sums (potential, kinetic, momentum and
// angular momentum per axis) are updated. The particle flagged last closes the frame: one
// output transaction then carries total, potential and kinetic energy (both halved) and the
// six momentum sums, and all sums return to zero. The back end runs the twenty products of
// a particle one after another through a single 32 by 32 bit multiplier, each issued, built
// from four partial products, negated if needed, saturated and written back. A two-entry
// queue accepts particles while one is being worked on, and the result waits in an output
// register while the next frame is worked on, until that frame's own result is due. The
// half step register is written through the configuration channel, which is always ready,
// and must only be changed while no particle is in flight.
module energy_momentum_reduction_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  emr_pkg::in_item_t                 in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output emr_pkg::out_item_t                out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic signed [emr_pkg::DATA_W-1:0] cfg_data_i
);

  logic signed [emr_pkg::DATA_W-1:0] half_step_q, half_step_d;

  logic              q_valid;
  logic              q_pop;
  emr_pkg::q_entry_t q_entry;
  emr_pkg::mul_req_t mul_req;
  emr_pkg::mul_rsp_t mul_rsp;

  assign cfg_ready_o = 1'b1;
  assign half_step_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : half_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_step_q <= '0;
    end else begin
      half_step_q <= half_step_d;
    end
  end

  emr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_entry_o  (q_entry)
  );

  emr_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  emr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .half_step_i (half_step_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .mul_req_o   (mul_req),
    .mul_rsp_i   (mul_rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  a_mul_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> ##8 mul_rsp.done)
    else $error("Multiplier result did not arrive eight cycles after its start.");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("Back end popped an empty queue.");

  a_pop_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> mul_req.start)
    else $error("First product was not issued right after a queue pop.");
`endif

endmodule

/* hdl/emr_front.sv */
module emr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  emr_pkg::in_item_t  in_item_i,
  output logic               q_valid_o,
  input  logic               q_pop_i,
  output emr_pkg::q_entry_t  q_entry_o
);

  localparam int PTR_W = $clog2(emr_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(emr_pkg::QUEUE_DEPTH + 1);

  emr_pkg::q_entry_t entries_q [emr_pkg::QUEUE_DEPTH];
  emr_pkg::q_entry_t new_entry;

  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(emr_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_stall_o = (count_q == CNT_W'(emr_pkg::QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != '0);
  assign q_entry_o  = entries_q[rd_ptr_q];

  // The last flag decides whether the back end closes the frame after this particle.
  always_comb begin
    new_entry.op   = in_item_i.last ? emr_pkg::OP_FLUSH : emr_pkg::OP_ACCUM;
    new_entry.item = in_item_i;
  end

  always_comb begin
    wr_ptr_d = push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = q_pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    case ({push, q_pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= new_entry;
    end
  end

endmodule

/* hdl/emr_mul.sv */
module emr_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  emr_pkg::mul_req_t req_i,
  output emr_pkg::mul_rsp_t rsp_o
);

  localparam logic [2:0] PH_LAST_PART = 3'd3;
  localparam logic [2:0] PH_LAST_ACC  = 3'd4;
  localparam logic [2:0] PH_NEG       = 3'd5;
  localparam logic [2:0] PH_SAT       = 3'd6;

  logic                             run_q, run_d;
  logic [2:0]                       cnt_q, cnt_d;
  logic                             done_q, done_d;
  logic [emr_pkg::ACC_W-1:0]        ma_q, ma_d;
  logic [emr_pkg::ACC_W-1:0]        mb_q, mb_d;
  logic                             neg_q, neg_d;
  logic [emr_pkg::ACC_W-1:0]        prod_q, prod_d;
  logic [1:0]                       psh_q, psh_d;
  logic [emr_pkg::PROD_W-1:0]       acc_q, acc_d;
  logic signed [emr_pkg::ACC_W-1:0] res_q, res_d;

  logic [emr_pkg::HALF_W-1:0]        half_a, half_b;
  logic [emr_pkg::PROD_W-1:0]        prod_term;
  logic signed [emr_pkg::PROD_W-1:0] shifted;
  logic [emr_pkg::ACC_W:0]           hi_bits;
  logic                              ovf;

  assign half_a = cnt_q[1] ? ma_q[emr_pkg::ACC_W-1:emr_pkg::HALF_W]
                           : ma_q[emr_pkg::HALF_W-1:0];
  assign half_b = cnt_q[0] ? mb_q[emr_pkg::ACC_W-1:emr_pkg::HALF_W]
                           : mb_q[emr_pkg::HALF_W-1:0];

  always_comb begin
    case (psh_q)
      2'd0:    prod_term = {{emr_pkg::ACC_W{1'b0}}, prod_q};
      2'd1:    prod_term = {{emr_pkg::HALF_W{1'b0}}, prod_q, {emr_pkg::HALF_W{1'b0}}};
      default: prod_term = {prod_q, {emr_pkg::ACC_W{1'b0}}};
    endcase
  end

  assign shifted = $signed(acc_q) >>> emr_pkg::FRAC_BITS;
  assign hi_bits = shifted[emr_pkg::PROD_W-1:emr_pkg::ACC_W-1];
  assign ovf     = !((&hi_bits) || (~|hi_bits));

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    ma_d   = ma_q;
    mb_d   = mb_q;
    neg_d  = neg_q;
    prod_d = prod_q;
    psh_d  = psh_q;
    acc_d  = acc_q;
    res_d  = res_q;
    if (req_i.start) begin
      ma_d  = req_i.a[emr_pkg::ACC_W-1] ? (~req_i.a + 1'b1) : req_i.a;
      mb_d  = req_i.b[emr_pkg::ACC_W-1] ? (~req_i.b + 1'b1) : req_i.b;
      neg_d = req_i.a[emr_pkg::ACC_W-1] ^ req_i.b[emr_pkg::ACC_W-1];
      acc_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (cnt_q <= PH_LAST_PART) begin
        prod_d = half_a * half_b;
        psh_d  = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
      end
      if ((cnt_q != '0) && (cnt_q <= PH_LAST_ACC)) begin
        acc_d = acc_q + prod_term;
      end
      if ((cnt_q == PH_NEG) && neg_q) begin
        acc_d = ~acc_q + 1'b1;
      end
      if (cnt_q == PH_SAT) begin
        if (ovf) begin
          res_d = acc_q[emr_pkg::PROD_W-1] ? emr_pkg::ACC_MIN : emr_pkg::ACC_MAX;
        end else begin
          res_d = shifted[emr_pkg::ACC_W-1:0];
        end
        done_d = 1'b1;
        run_d  = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
    psh_q  <= psh_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

/* hdl/emr_back.sv */
module emr_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [emr_pkg::DATA_W-1:0] half_step_i,
  input  logic                              q_valid_i,
  input  emr_pkg::q_entry_t                 q_entry_i,
  output logic                              q_pop_o,
  output emr_pkg::mul_req_t                 mul_req_o,
  input  emr_pkg::mul_rsp_t                 mul_rsp_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output emr_pkg::out_item_t                out_item_o
);

  localparam int NUM_AXES  = 3;
  localparam int NUM_STEPS = 20;
  localparam int STEP_W    = $clog2(NUM_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef enum logic [1:0] {
    OPA_FORCE,
    OPA_MASS,
    OPA_POS,
    OPA_VEL
  } opa_e;

  typedef enum logic [1:0] {
    OPB_HALF_STEP,
    OPB_POT,
    OPB_VEL,
    OPB_TMP
  } opb_e;

  typedef enum logic [2:0] {
    ACT_VEL,
    ACT_POT,
    ACT_TMP_SET,
    ACT_TMP_ADD,
    ACT_TMP_SUB,
    ACT_KIN,
    ACT_MOM,
    ACT_ANG
  } act_e;

  typedef struct packed {
    opa_e       src_a;
    logic [1:0] ax_a;
    opb_e       src_b;
    logic [1:0] ax_b;
    act_e       act;
    logic [1:0] ax_d;
  } uop_t;

  function automatic uop_t mk(input opa_e a, input logic [1:0] ax_a, input opb_e b,
                              input logic [1:0] ax_b, input act_e act,
                              input logic [1:0] ax_d);
    uop_t u;
    u.src_a = a;
    u.ax_a  = ax_a;
    u.src_b = b;
    u.ax_b  = ax_b;
    u.act   = act;
    u.ax_d  = ax_d;
    return u;
  endfunction

  // One product per step through the shared multiplier.
  function automatic uop_t prog(input logic [STEP_W-1:0] s);
    case (s)
      0:       return mk(OPA_FORCE, AX_X, OPB_HALF_STEP, AX_X, ACT_VEL, AX_X);
      1:       return mk(OPA_FORCE, AX_Y, OPB_HALF_STEP, AX_X, ACT_VEL, AX_Y);
      2:       return mk(OPA_FORCE, AX_Z, OPB_HALF_STEP, AX_X, ACT_VEL, AX_Z);
      3:       return mk(OPA_MASS,  AX_X, OPB_POT,       AX_X, ACT_POT, AX_X);
      4:       return mk(OPA_VEL,   AX_X, OPB_VEL,       AX_X, ACT_TMP_SET, AX_X);
      5:       return mk(OPA_VEL,   AX_Y, OPB_VEL,       AX_Y, ACT_TMP_ADD, AX_X);
      6:       return mk(OPA_VEL,   AX_Z, OPB_VEL,       AX_Z, ACT_TMP_ADD, AX_X);
      7:       return mk(OPA_MASS,  AX_X, OPB_TMP,       AX_X, ACT_KIN, AX_X);
      8:       return mk(OPA_POS,   AX_Y, OPB_VEL,       AX_Z, ACT_TMP_SET, AX_X);
      9:       return mk(OPA_POS,   AX_Z, OPB_VEL,       AX_Y, ACT_TMP_SUB, AX_X);
      10:      return mk(OPA_MASS,  AX_X, OPB_TMP,       AX_X, ACT_ANG, AX_X);
      11:      return mk(OPA_POS,   AX_Z, OPB_VEL,       AX_X, ACT_TMP_SET, AX_X);
      12:      return mk(OPA_POS,   AX_X, OPB_VEL,       AX_Z, ACT_TMP_SUB, AX_X);
      13:      return mk(OPA_MASS,  AX_X, OPB_TMP,       AX_X, ACT_ANG, AX_Y);
      14:      return mk(OPA_POS,   AX_X, OPB_VEL,       AX_Y, ACT_TMP_SET, AX_X);
      15:      return mk(OPA_POS,   AX_Y, OPB_VEL,       AX_X, ACT_TMP_SUB, AX_X);
      16:      return mk(OPA_MASS,  AX_X, OPB_TMP,       AX_X, ACT_ANG, AX_Z);
      17:      return mk(OPA_MASS,  AX_X, OPB_VEL,       AX_X, ACT_MOM, AX_X);
      18:      return mk(OPA_MASS,  AX_X, OPB_VEL,       AX_Y, ACT_MOM, AX_Y);
      default: return mk(OPA_MASS,  AX_X, OPB_VEL,       AX_Z, ACT_MOM, AX_Z);
    endcase
  endfunction

  function automatic logic signed [emr_pkg::DATA_W-1:0] pick_data(
      input logic [1:0] ax, input logic signed [emr_pkg::DATA_W-1:0] x,
      input logic signed [emr_pkg::DATA_W-1:0] y, input logic signed [emr_pkg::DATA_W-1:0] z);
    case (ax)
      AX_Y:    return y;
      AX_Z:    return z;
      default: return x;
    endcase
  endfunction

  function automatic logic signed [emr_pkg::ACC_W-1:0] sext_data(
      input logic signed [emr_pkg::DATA_W-1:0] x);
    return {{(emr_pkg::ACC_W-emr_pkg::DATA_W){x[emr_pkg::DATA_W-1]}}, x};
  endfunction

  function automatic logic signed [emr_pkg::ACC_W-1:0] sat_add(
      input logic signed [emr_pkg::ACC_W-1:0] a, input logic signed [emr_pkg::ACC_W-1:0] b);
    logic signed [emr_pkg::ACC_W-1:0] r;
    r = a + b;
    if ((a[emr_pkg::ACC_W-1] == b[emr_pkg::ACC_W-1]) &&
        (r[emr_pkg::ACC_W-1] != a[emr_pkg::ACC_W-1])) begin
      r = a[emr_pkg::ACC_W-1] ? emr_pkg::ACC_MIN : emr_pkg::ACC_MAX;
    end
    return r;
  endfunction

  function automatic logic signed [emr_pkg::ACC_W-1:0] sat_sub(
      input logic signed [emr_pkg::ACC_W-1:0] a, input logic signed [emr_pkg::ACC_W-1:0] b);
    logic signed [emr_pkg::ACC_W-1:0] r;
    r = a - b;
    if ((a[emr_pkg::ACC_W-1] != b[emr_pkg::ACC_W-1]) &&
        (r[emr_pkg::ACC_W-1] != a[emr_pkg::ACC_W-1])) begin
      r = a[emr_pkg::ACC_W-1] ? emr_pkg::ACC_MIN : emr_pkg::ACC_MAX;
    end
    return r;
  endfunction

  logic [1:0]                       state_q, state_d;
  logic [STEP_W-1:0]                step_q, step_d;
  emr_pkg::q_entry_t                item_q, item_d;
  logic signed [emr_pkg::VEL_W-1:0] v_q [NUM_AXES];
  logic signed [emr_pkg::VEL_W-1:0] v_d [NUM_AXES];
  logic signed [emr_pkg::ACC_W-1:0] tmp_q, tmp_d;
  logic signed [emr_pkg::ACC_W-1:0] psum_q, psum_d;
  logic signed [emr_pkg::ACC_W-1:0] ksum_q, ksum_d;
  logic signed [emr_pkg::ACC_W-1:0] mom_q [NUM_AXES];
  logic signed [emr_pkg::ACC_W-1:0] mom_d [NUM_AXES];
  logic signed [emr_pkg::ACC_W-1:0] ang_q [NUM_AXES];
  logic signed [emr_pkg::ACC_W-1:0] ang_d [NUM_AXES];
  emr_pkg::out_item_t               out_q, out_d;
  logic                             out_valid_q, out_valid_d;

  uop_t                             u;
  logic signed [emr_pkg::ACC_W-1:0] op_a, op_b;
  logic signed [emr_pkg::VEL_W-1:0] vel_a, vel_b;
  logic signed [emr_pkg::DATA_W-1:0] vel_in;
  logic signed [emr_pkg::VEL_W-1:0] vel_ext;
  logic signed [emr_pkg::ACC_W-1:0] pe_half, ke_half;

  assign u = prog(step_q);

  always_comb begin
    case (u.ax_a)
      AX_Y:    vel_a = v_q[1];
      AX_Z:    vel_a = v_q[2];
      default: vel_a = v_q[0];
    endcase
    case (u.ax_b)
      AX_Y:    vel_b = v_q[1];
      AX_Z:    vel_b = v_q[2];
      default: vel_b = v_q[0];
    endcase
  end

  always_comb begin
    case (u.src_a)
      OPA_FORCE: op_a = sext_data(pick_data(u.ax_a, item_q.item.force_x,
                                            item_q.item.force_y, item_q.item.force_z));
      OPA_MASS:  op_a = {{(emr_pkg::ACC_W-emr_pkg::MASS_W){1'b0}}, item_q.item.mass};
      OPA_POS:   op_a = sext_data(pick_data(u.ax_a, item_q.item.pos_x,
                                            item_q.item.pos_y, item_q.item.pos_z));
      OPA_VEL:   op_a = {{(emr_pkg::ACC_W-emr_pkg::VEL_W){vel_a[emr_pkg::VEL_W-1]}}, vel_a};
      default:   op_a = '0;
    endcase
    case (u.src_b)
      OPB_HALF_STEP: op_b = sext_data(half_step_i);
      OPB_POT:       op_b = sext_data(item_q.item.potential);
      OPB_VEL:       op_b = {{(emr_pkg::ACC_W-emr_pkg::VEL_W){vel_b[emr_pkg::VEL_W-1]}}, vel_b};
      OPB_TMP:       op_b = tmp_q;
      default:       op_b = '0;
    endcase
  end

  assign mul_req_o.start = (state_q == ST_ISSUE);
  assign mul_req_o.a     = op_a;
  assign mul_req_o.b     = op_b;

  assign vel_in  = pick_data(u.ax_d, item_q.item.vel_x, item_q.item.vel_y, item_q.item.vel_z);
  assign vel_ext = {{(emr_pkg::VEL_W-emr_pkg::DATA_W){vel_in[emr_pkg::DATA_W-1]}}, vel_in};
  assign pe_half = psum_q >>> 1;
  assign ke_half = ksum_q >>> 1;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    item_d      = item_q;
    v_d         = v_q;
    tmp_d       = tmp_q;
    psum_d      = psum_q;
    ksum_d      = ksum_q;
    mom_d       = mom_q;
    ang_d       = ang_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    q_pop_o     = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_entry_i;
          step_d  = '0;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (mul_rsp_i.done) begin
          case (u.act)
            ACT_VEL: begin
              for (int i = 0; i < NUM_AXES; i++) begin
                if (u.ax_d == 2'(i)) begin
                  v_d[i] = vel_ext + mul_rsp_i.res[emr_pkg::VEL_W-1:0];
                end
              end
            end
            ACT_POT:     psum_d = sat_add(psum_q, mul_rsp_i.res);
            ACT_TMP_SET: tmp_d  = mul_rsp_i.res;
            ACT_TMP_ADD: tmp_d  = sat_add(tmp_q, mul_rsp_i.res);
            ACT_TMP_SUB: tmp_d  = sat_sub(tmp_q, mul_rsp_i.res);
            ACT_KIN:     ksum_d = sat_add(ksum_q, mul_rsp_i.res);
            ACT_MOM: begin
              for (int i = 0; i < NUM_AXES; i++) begin
                if (u.ax_d == 2'(i)) begin
                  mom_d[i] = sat_add(mom_q[i], mul_rsp_i.res);
                end
              end
            end
            ACT_ANG: begin
              for (int i = 0; i < NUM_AXES; i++) begin
                if (u.ax_d == 2'(i)) begin
                  ang_d[i] = sat_add(ang_q[i], mul_rsp_i.res);
                end
              end
            end
            default: tmp_d = tmp_q;
          endcase
          if (step_q == LAST_STEP) begin
            state_d = (item_q.op == emr_pkg::OP_FLUSH) ? ST_EMIT : ST_IDLE;
          end else begin
            step_d  = step_q + 1'b1;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.total_energy     = sat_add(pe_half, ke_half);
          out_d.potential_energy = pe_half;
          out_d.kinetic_energy   = ke_half;
          out_d.momentum_x       = mom_q[0];
          out_d.momentum_y       = mom_q[1];
          out_d.momentum_z       = mom_q[2];
          out_d.angular_x        = ang_q[0];
          out_d.angular_y        = ang_q[1];
          out_d.angular_z        = ang_q[2];
          out_valid_d            = 1'b1;
          psum_d                 = '0;
          ksum_d                 = '0;
          for (int i = 0; i < NUM_AXES; i++) begin
            mom_d[i] = '0;
            ang_d[i] = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      psum_q      <= '0;
      ksum_q      <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        mom_q[i] <= '0;
        ang_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      psum_q      <= psum_d;
      ksum_q      <= ksum_d;
      mom_q       <= mom_d;
      ang_q       <= ang_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    v_q    <= v_d;
    tmp_q  <= tmp_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
